// ----- rtl/ftac_pkg.sv -----
// Shared types and constants for the five-tuple classifier.
package ftac_pkg;

   localparam logic [1:0] OP_CLASSIFY  = 2'd0;
   localparam logic [1:0] OP_WRITE     = 2'd1;
   localparam logic [1:0] OP_BLACKLIST = 2'd2;

   localparam logic [1:0] ACT_ALLOW = 2'd0;
   localparam logic [1:0] ACT_DENY  = 2'd1;
   localparam logic [1:0] ACT_LOG   = 2'd2;
   localparam logic [1:0] ACT_BAD   = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  rule_slot;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
      logic [31:0] src_mask;
      logic [31:0] dst_mask;
      logic [15:0] src_port_max;
      logic [15:0] dst_port_max;
      logic [1:0]  rule_action;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic        rule_matched;
      logic [3:0]  matched_index;
      logic [31:0] hit_count;
      logic        blacklisted;
      logic        status;
   } rsp_type;

endpackage

// ----- rtl/ftac_req_if.sv -----
// Request channel interface.
interface ftac_req_if
   import ftac_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ftac_rsp_if.sv -----
// Response channel interface.
interface ftac_rsp_if
   import ftac_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ftac_rule_cell.sv -----
// One rule cell: stored rule, hit counter and match compare.
module ftac_rule_cell
   import ftac_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  req_type     wr_data,
   input  req_type     key,
   input  logic        inc_en,
   output logic        hit,
   output logic [1:0]  action,
   output logic [31:0] count_next
);
   logic [31:0] sv_ff, sm_ff, dv_ff, dm_ff;
   logic [15:0] spl_ff, sph_ff, dpl_ff, dph_ff;
   logic [7:0]  pr_ff;
   logic [1:0]  act_ff;
   logic [31:0] cnt_ff, cnt_in;

   // rule storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sv_ff  <= wr_data.src_ip;
         sm_ff  <= wr_data.src_mask;
         dv_ff  <= wr_data.dst_ip;
         dm_ff  <= wr_data.dst_mask;
         spl_ff <= wr_data.src_port;
         sph_ff <= wr_data.src_port_max;
         dpl_ff <= wr_data.dst_port;
         dph_ff <= wr_data.dst_port_max;
         pr_ff  <= wr_data.protocol;
         act_ff <= (wr_data.rule_action == ACT_BAD) ? ACT_DENY : wr_data.rule_action;
      end
   end

   // match compare
   assign hit = ((key.src_ip & sm_ff) == sv_ff) && ((key.dst_ip & dm_ff) == dv_ff)
             && (pr_ff == 8'd0 || pr_ff == key.protocol)
             && key.src_port >= spl_ff && key.src_port <= sph_ff
             && key.dst_port >= dpl_ff && key.dst_port <= dph_ff;
   assign action     = act_ff;
   assign count_next = (cnt_ff == '1) ? cnt_ff : cnt_ff + 32'd1;

   // saturating hit counter
   always_comb begin
      cnt_in = cnt_ff;
      if (wr_en) cnt_in = '0;
      else if (inc_en) cnt_in = count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end
endmodule

// ----- rtl/ftac_deny_cell.sv -----
// One blacklist cell: address register, valid flag and compare.
module ftac_deny_cell (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [31:0] wr_addr,
   input  logic [31:0] key,
   output logic        used,
   output logic        hit
);
   logic [31:0] addr_ff;
   logic        used_ff;

   always_ff @(posedge clock) begin
      if (wr_en) addr_ff <= wr_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= 1'b0;
      else if (wr_en) used_ff <= 1'b1;
   end

   assign used = used_ff;
   assign hit  = used_ff && (addr_ff == key);
endmodule

// ----- rtl/five_tuple_acl_classifier_unit.sv -----
// Five-tuple first-match classifier top level.
// One transaction is accepted per cycle when the response register is free or
// being drained: rule and blacklist cells compare the request in parallel, a
// priority pick chooses the lowest matching rule, and the response register
// holds the result; a blacklist insert fills the next
// free cell in order, so the blacklist acts as a set with drop-when-full.
module five_tuple_acl_classifier_unit
   import ftac_pkg::*;
   #(
   parameter int RULE_SLOTS = 16,
   parameter int DENY_SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data,
   ftac_req_if.sink   req,
   ftac_rsp_if.source rsp
);
   localparam int RW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

   logic [4:0]  rules_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        take;
   req_type     q;

   logic [RULE_SLOTS-1:0] r_hit, r_wr, r_inc;
   logic [1:0]  r_act [RULE_SLOTS];
   logic [31:0] r_cnt [RULE_SLOTS];
   logic [DENY_SLOTS-1:0] d_used, d_hit, d_wr;

   assign q         = req.data;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;

   // config register
   always_ff @(posedge clock) begin
      if (reset) rules_ff <= '0;
      else if (csr_wr_en) rules_ff <= csr_wr_data;
   end

   logic black;
   assign black = |d_hit;

   // first matching rule among those in use
   logic            found;
   logic [RW-1:0]   pick;
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int k = RULE_SLOTS - 1; k >= 0; k--) begin
         if (r_hit[k] && (32'(k) < 32'(rules_ff))) begin
            found = 1'b1;
            pick  = RW'(k);
         end
      end
   end

   // rule cells
   for (genvar k = 0; k < RULE_SLOTS; k++) begin : g_rule
      assign r_wr[k]  = take && q.opcode == OP_WRITE && 32'(q.rule_slot) == k;
      assign r_inc[k] = take && q.opcode == OP_CLASSIFY && !black && found
                     && pick == RW'(k);
      ftac_rule_cell u_rule (
         .clock(clock), .reset(reset), .wr_en(r_wr[k]), .wr_data(q), .key(q),
         .inc_en(r_inc[k]), .hit(r_hit[k]), .action(r_act[k]),
         .count_next(r_cnt[k]));
   end

   // blacklist: next free cell takes a new address
   logic full;
   assign full = &d_used;
   for (genvar i = 0; i < DENY_SLOTS; i++) begin : g_deny
      if (i == 0) begin : g_first
         assign d_wr[i] = take && q.opcode == OP_BLACKLIST && !black && !d_used[i];
      end else begin : g_rest
         assign d_wr[i] = take && q.opcode == OP_BLACKLIST && !black && !d_used[i]
                       && d_used[i-1];
      end
      ftac_deny_cell u_deny (
         .clock(clock), .reset(reset), .wr_en(d_wr[i]), .wr_addr(q.src_ip),
         .key(q.src_ip), .used(d_used[i]), .hit(d_hit[i]));
   end

   // response build
   always_comb begin
      rsp_in = '0;
      case (q.opcode)
         OP_CLASSIFY: begin
            rsp_in.verdict = ACT_DENY;
            if (black) rsp_in.blacklisted = 1'b1;
            else if (found) begin
               rsp_in.verdict       = r_act[pick];
               rsp_in.rule_matched  = 1'b1;
               rsp_in.matched_index = 4'(pick);
               rsp_in.hit_count     = r_cnt[pick];
            end
         end
         OP_BLACKLIST: rsp_in.status = !black && full;
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (take) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // checks
   a_onehot_inc: assert property (@(posedge clock) disable iff (reset) $onehot0(r_inc))
      else $error("more than one counter incremented");
   a_onehot_dw: assert property (@(posedge clock) disable iff (reset) $onehot0(d_wr))
      else $error("more than one blacklist cell written");
   a_black_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.blacklisted |-> !rsp_ff.rule_matched)
      else $error("blacklisted and matched together");
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the five-tuple classifier: directed table, then random traffic.
module tb_top
   import ftac_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RULES = 16;
   localparam int N_DENY  = 16;
   localparam int CYCLE_LIMIT = 200000;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;

   ftac_req_if req_ch ();
   ftac_rsp_if rsp_ch ();

   five_tuple_acl_classifier_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source)
   );

   // Shadow state of the classifier
   logic [31:0] acl_sip   [N_RULES];
   logic [31:0] acl_smask [N_RULES];
   logic [31:0] acl_dip   [N_RULES];
   logic [31:0] acl_dmask [N_RULES];
   logic [15:0] acl_splo  [N_RULES];
   logic [15:0] acl_sphi  [N_RULES];
   logic [15:0] acl_dplo  [N_RULES];
   logic [15:0] acl_dphi  [N_RULES];
   logic [7:0]  acl_proto [N_RULES];
   logic [1:0]  acl_act   [N_RULES];
   logic [31:0] acl_hits  [N_RULES];
   logic [31:0] deny_list [$];
   int          rules_active;
   int          rules_written;

   rsp_type verdict_queue [$];
   int      error_count;
   int      cycle_count;
   bit      long_stall;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Predict the response of one transaction and update the shadow state
   function automatic rsp_type classify_predict(input req_type r);
      rsp_type o;
      bit      listed;
      int      lim;
      logic [1:0] a;
      o = '0;
      listed = 0;
      foreach (deny_list[i]) if (deny_list[i] == r.src_ip) listed = 1;
      case (r.opcode)
         OP_CLASSIFY: begin
            o.verdict = ACT_DENY;
            if (listed) begin
               o.blacklisted = 1'b1;
            end else begin
               lim = rules_active > N_RULES ? N_RULES : rules_active;
               for (int k = 0; k < lim; k++) begin
                  if ((r.src_ip & acl_smask[k]) == acl_sip[k] &&
                      (r.dst_ip & acl_dmask[k]) == acl_dip[k] &&
                      (acl_proto[k] == 8'd0 || acl_proto[k] == r.protocol) &&
                      r.src_port >= acl_splo[k] && r.src_port <= acl_sphi[k] &&
                      r.dst_port >= acl_dplo[k] && r.dst_port <= acl_dphi[k]) begin
                     if (acl_hits[k] != 32'hFFFF_FFFF) acl_hits[k]++;
                     o.verdict       = acl_act[k];
                     o.rule_matched  = 1'b1;
                     o.matched_index = 4'(k);
                     o.hit_count     = acl_hits[k];
                     break;
                  end
               end
            end
         end
         OP_WRITE: begin
            a = (r.rule_action == ACT_BAD) ? ACT_DENY : r.rule_action;
            acl_sip[r.rule_slot]   = r.src_ip;
            acl_dip[r.rule_slot]   = r.dst_ip;
            acl_splo[r.rule_slot]  = r.src_port;
            acl_dplo[r.rule_slot]  = r.dst_port;
            acl_proto[r.rule_slot] = r.protocol;
            acl_smask[r.rule_slot] = r.src_mask;
            acl_dmask[r.rule_slot] = r.dst_mask;
            acl_sphi[r.rule_slot]  = r.src_port_max;
            acl_dphi[r.rule_slot]  = r.dst_port_max;
            acl_act[r.rule_slot]   = a;
            acl_hits[r.rule_slot]  = '0;
            if (r.rule_slot >= rules_written) rules_written = r.rule_slot + 1;
         end
         OP_BLACKLIST: begin
            if (!listed) begin
               if (deny_list.size() < N_DENY) deny_list = {deny_list, r.src_ip};
               else o.status = 1'b1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Send one transaction after a random gap; wait for acceptance.
   // Valid stays high after acceptance so back-to-back items need no gap;
   // it drops only before an idle stretch.
   task automatic send_row(input req_type r, input bit has_want, input rsp_type want);
      int      gap;
      rsp_type pred;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      pred = classify_predict(r);
      verdict_queue = {verdict_queue, has_want ? want : pred};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_request(input req_type r);
      send_row(r, 1'b0, '0);
   endtask

   task automatic write_rules_in_use(input logic [4:0] n);
      req_ch.valid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rules_active = n;
   endtask

   // Random rule with a chance to match the packet pool
   function automatic req_type random_rule(input int slot);
      req_type r;
      r = '0;
      r.opcode       = OP_WRITE;
      r.rule_slot    = 4'(slot);
      r.src_mask     = ($urandom_range(0, 2) == 0) ? $urandom : 32'hFFFF_FF00;
      r.dst_mask     = ($urandom_range(0, 2) == 0) ? 32'h0 : 32'hFFFF_0000;
      r.src_ip       = {24'h0A0000, 8'($urandom_range(0, 3))} & r.src_mask;
      r.dst_ip       = {16'hC0A8, 16'($urandom)} & r.dst_mask;
      r.protocol     = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(6, 7));
      r.src_port     = 16'($urandom_range(0, 2000));
      r.src_port_max = 16'($urandom_range(1000, 65535));
      r.dst_port     = 16'($urandom_range(0, 100));
      r.dst_port_max = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
      r.rule_action  = 2'($urandom);
      return r;
   endfunction

   function automatic req_type random_packet();
      req_type     r;
      logic [223:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      r.opcode = OP_CLASSIFY;
      if ($urandom_range(0, 3) != 0) begin
         r.src_ip = {24'h0A0000, 8'($urandom_range(0, 7))};
         r.dst_ip = {16'hC0A8, 16'($urandom)};
         r.protocol = 8'($urandom_range(5, 8));
      end
      return r;
   endfunction

   // Response side: random stalls plus one long hold-off
   initial begin
      int wait_cycles;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_stall) begin
            rsp_ch.ready <= 1'b0;
            repeat (40) @(posedge clock);
            long_stall = 0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         if (wait_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_ch.data.verdict), 0);
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_ch.data.verdict != want.verdict)
               report_mismatch("verdict", 32'(rsp_ch.data.verdict), 32'(want.verdict));
            if (rsp_ch.data.rule_matched != want.rule_matched)
               report_mismatch("rule_matched", 32'(rsp_ch.data.rule_matched),
                               32'(want.rule_matched));
            if (rsp_ch.data.matched_index != want.matched_index)
               report_mismatch("matched_index", 32'(rsp_ch.data.matched_index),
                               32'(want.matched_index));
            if (rsp_ch.data.hit_count != want.hit_count)
               report_mismatch("hit_count", rsp_ch.data.hit_count, want.hit_count);
            if (rsp_ch.data.blacklisted != want.blacklisted)
               report_mismatch("blacklisted", 32'(rsp_ch.data.blacklisted),
                               32'(want.blacklisted));
            if (rsp_ch.data.status != want.status)
               report_mismatch("status", 32'(rsp_ch.data.status), 32'(want.status));
         end
      end
   end

   // Directed table: rows with a typed expectation are checked against it
   typedef struct {
      req_type r;
      bit      has_want;
      rsp_type want;
   } table_row;

   initial begin
      table_row rows [$];
      table_row row;
      req_type  q;
      int       n;
      error_count  = 0;
      rules_active = 0;
      rules_written = 0;
      long_stall   = 0;
      foreach (acl_hits[i]) acl_hits[i] = '0;
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // classify with no rules: deny
      q = '0; q.opcode = OP_CLASSIFY; q.src_ip = 32'hFFFF_FFFF;
      row.r = q; row.has_want = 1; row.want = '0; row.want.verdict = ACT_DENY;
      rows = {rows, row};
      // unused opcode: all zero
      q = '1; q.opcode = 2'd3;
      row.r = q; row.has_want = 1; row.want = '0; rows = {rows, row};
      // wildcard rule in slot 0, action code three stored as deny
      q = '0; q.opcode = OP_WRITE; q.rule_action = ACT_BAD;
      q.src_port_max = 16'hFFFF; q.dst_port_max = 16'hFFFF;
      row.r = q; row.has_want = 1; row.want = '0; rows = {rows, row};
      // slot 15 extremes, allow with exact match
      q = '1; q.opcode = OP_WRITE; q.rule_action = ACT_ALLOW;
      row.r = q; row.has_want = 1; row.want = '0; rows = {rows, row};
      // log rule in slot 1 for protocol 17 and port range
      q = '0; q.opcode = OP_WRITE; q.rule_slot = 4'd1; q.protocol = 8'd17;
      q.src_port = 16'd100; q.src_port_max = 16'd200;
      q.dst_port_max = 16'hFFFF; q.rule_action = ACT_LOG;
      row.r = q; row.has_want = 1; row.want = '0; rows = {rows, row};
      foreach (rows[i]) begin
         send_row(rows[i].r, rows[i].has_want, rows[i].want);
      end
      rows.delete();

      write_rules_in_use(5'd31);   // saturates to the table size
      write_rules_in_use(5'd16);
      // remaining directed classifies against the predictor
      q = '1; q.opcode = OP_CLASSIFY; send_request(q);           // wildcard in slot 0 hits
      q = '0; q.opcode = OP_CLASSIFY; send_request(q);           // slot 0 hit
      q = '0; q.opcode = OP_CLASSIFY; q.src_ip = 32'h1; send_request(q);
      q = '0; q.opcode = OP_BLACKLIST; q.src_ip = 32'h0A00_0001; send_request(q);
      q.src_ip = 32'h0A00_0001; send_request(q);                 // duplicate add
      q = '0; q.opcode = OP_CLASSIFY; q.src_ip = 32'h0A00_0001; send_request(q);
      // exercise slot rewrite so slots 1..14 become defined
      for (int s = 1; s < 15; s++) send_request(random_rule(s));
      // deny-all in slot 0 rewritten to something narrower
      send_request(random_rule(0));
      write_rules_in_use(5'd1);
      for (int i = 0; i < 20; i++) send_request(random_packet());

      // random phases; each phase first sets the number of rules in use
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_rules_in_use(5'd0);
            1: write_rules_in_use(5'd16);
            5: write_rules_in_use(5'd31);
            default: write_rules_in_use(5'($urandom_range(1, 16)));
         endcase
         if (phase == 2) long_stall = 1;
         for (int i = 0; i < 100; i++) begin
            n = $urandom_range(0, 19);
            if (n < 14) begin
               send_request(random_packet());
            end else if (n < 17) begin
               send_request(random_rule($urandom_range(0, 15)));
            end else if (n < 19) begin
               q = random_packet(); q.opcode = OP_BLACKLIST;
               if ($urandom_range(0, 1) == 0) q.src_ip = {24'h0A0000, 8'($urandom_range(0, 7))};
               send_request(q);
            end else begin
               q = random_packet(); q.opcode = 2'd3; send_request(q);
            end
         end
      end
      req_ch.valid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
